>>> src/sws_pkg.sv
// Shared types and constants of the sliding window sender.
package sws_pkg;

  localparam int unsigned SeqSpace    = 8;
  localparam int unsigned SeqW        = 3;
  localparam int unsigned PayloadBits = 64;
  localparam int unsigned CfgW        = 3;
  localparam int unsigned CfgIdxW     = 1;

  typedef logic [SeqW-1:0]        seq_t;
  typedef logic [PayloadBits-1:0] payload_t;
  typedef logic [CfgW-1:0]        cfg_t;

  typedef enum logic [1:0] {
    CmdSend  = 2'd0,
    CmdAck   = 2'd1,
    CmdTimer = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StSent        = 3'd0,
    StWindowFull  = 3'd1,
    StAckAccepted = 3'd2,
    StCorrupt     = 3'd3,
    StDuplicate   = 3'd4,
    StFastResend  = 3'd5,
    StTimeoutSend = 3'd6,
    StIdle        = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    TmrLeave   = 2'd0,
    TmrRestart = 2'd1,
    TmrStop    = 2'd2,
    TmrUnused  = 2'd3
  } timer_e;

  localparam logic [CfgIdxW-1:0] CfgWindowSize  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgDupAckLimit = 1'd1;

  localparam cfg_t WindowSizeRst  = 3'd7;
  localparam cfg_t DupAckLimitRst = 3'd3;

  typedef struct packed {
    logic [1:0] cmd;
    payload_t   msg_payload;
    seq_t       ack_number;
    logic       ack_intact;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       tx_valid;
    seq_t       tx_seq;
    payload_t   tx_payload;
    logic [1:0] timer_action;
    seq_t       window_base;
    seq_t       next_to_send;
  } out_t;

endpackage

>>> src/sws_ram.sv
// Generic simple dual-port RAM with registered read.
module sws_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/sliding_window_sender_unit.sv
// Top level of the sliding window sender: pointer logic, payload RAM, output stages.
//
// Usage: one event per input beat (send, ack, timer expiry) on in_valid_i /
// in_ready_o; exactly one result beat per event on out_valid_o / out_ready_i,
// in event order. Window size and duplicate-ack limit are written through
// cfg_we_i / cfg_idx_i / cfg_wdata_i while no event is in flight.
// Pointers and the duplicate count live in flops and update at the accepting
// edge; payloads live in an 8-entry RAM with registered read.
// Stages: two register stages (read stage, output register) lie between the
// accepting edge and out_valid_o.
// Throughput: one event per cycle unless the output stalls; the base entry read
// for a resend is issued in the accept cycle and lands in the stage behind it,
// so there is no interlock (a resent entry was always written by an earlier send).
// Reset: base, next and duplicate count clear, window size is 7, limit is 3;
// the RAM is not cleared, since only written entries are ever read.
// Receiver stall: the output register holds its beat and one more event is
// taken into the read stage; after that in_ready_o drops until out_ready_i.
module sliding_window_sender_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  sws_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output sws_pkg::out_t                     out_data_o,
  input  logic                              cfg_we_i,
  input  logic [sws_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [sws_pkg::CfgW-1:0]          cfg_wdata_i
);
  import sws_pkg::*;

  seq_t base_q, base_d;
  seq_t next_q, next_d;
  seq_t dup_q,  dup_d;
  cfg_t win_size_q, dup_limit_q;

  logic in_acc;
  seq_t count, ack_dist, dup_inc;
  logic win_full, send_ok, ram_we, ram_re;
  out_t res;

  logic     s1_valid_q, s1_use_ram_q, s1_adv;
  out_t     s1_res_q;
  payload_t ram_rdata;
  logic     out_valid_q;
  out_t     out_q, s1_resolved;

  assign in_acc   = in_valid_i && in_ready_o;
  assign count    = next_q - base_q;
  assign ack_dist = in_data_i.ack_number - base_q;
  assign dup_inc  = dup_q + seq_t'(1);
  assign win_full = (count >= win_size_q) || (count >= seq_t'(SeqSpace - 1));

  // one event resolved per cycle while in_ready_o is high; the payload of a resend comes from RAM
  always_comb begin
    base_d  = base_q;
    next_d  = next_q;
    dup_d   = dup_q;
    send_ok = 1'b0;
    ram_re  = 1'b0;
    res     = '0;
    res.status       = StIdle;
    res.timer_action = TmrLeave;
    unique case (in_data_i.cmd)
      CmdSend: begin
        if (win_full) begin
          res.status = StWindowFull;
        end else begin
          send_ok         = 1'b1;
          res.status      = StSent;
          res.tx_valid    = 1'b1;
          res.tx_seq      = next_q;
          res.tx_payload  = in_data_i.msg_payload;
          if (count == '0) begin
            res.timer_action = TmrRestart;
          end
          next_d = next_q + seq_t'(1);
        end
      end
      CmdAck: begin
        if (!in_data_i.ack_intact) begin
          res.status = StCorrupt;
        end else if (ack_dist < count) begin
          res.status = StAckAccepted;
          base_d     = in_data_i.ack_number + seq_t'(1);
          dup_d      = '0;
          res.timer_action = (base_d != next_q) ? TmrRestart : TmrStop;
        end else begin
          dup_d      = dup_inc;
          res.status = StDuplicate;
          if (dup_inc >= dup_limit_q) begin
            dup_d = '0;
            if (count != '0) begin
              ram_re           = 1'b1;
              res.status       = StFastResend;
              res.tx_valid     = 1'b1;
              res.tx_seq       = base_q;
              res.timer_action = TmrRestart;
            end
          end
        end
      end
      CmdTimer: begin
        if (count != '0) begin
          ram_re           = 1'b1;
          res.status       = StTimeoutSend;
          res.tx_valid     = 1'b1;
          res.tx_seq       = base_q;
          res.timer_action = TmrRestart;
        end
      end
      default: begin
        res.status = StIdle;
      end
    endcase
    res.window_base  = base_d;
    res.next_to_send = next_d;
  end

  assign ram_we = in_acc && send_ok;

  sws_ram #(
    .Width (PayloadBits),
    .Depth (SeqSpace)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (next_q),
    .wdata_i (in_data_i.msg_payload),
    .re_i    (in_acc && ram_re),
    .raddr_i (base_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      next_q <= '0;
      dup_q  <= '0;
    end else if (in_acc) begin
      base_q <= base_d;
      next_q <= next_d;
      dup_q  <= dup_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q  <= WindowSizeRst;
      dup_limit_q <= DupAckLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWindowSize:  win_size_q  <= cfg_wdata_i;
        CfgDupAckLimit: dup_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // read stage: waits for RAM data, may hold one beat behind a stalled output
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_comb begin
    s1_resolved = s1_res_q;
    if (s1_use_ram_q) begin
      s1_resolved.tx_payload = ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_res_q     <= res;
      s1_use_ram_q <= ram_re;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= s1_resolved;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a resend only reads an entry that an earlier send wrote
  a_resend_outstanding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ram_re) |-> (base_q != next_q))
    else $error("resend with nothing outstanding");

  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && in_acc && ram_re))
    else $error("RAM read and write in one cycle");

  a_next_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && send_ok) |=> (next_q == $past(next_q) + seq_t'(1)))
    else $error("next sequence did not advance on send");

  // RAM data only matters for a beat that reads it
  a_read_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && (!s1_use_ram_q || $stable(ram_rdata))))
    else $error("read stage lost its beat or RAM data while stalled");

  a_no_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.tx_valid) |-> (out_q.tx_payload == '0 && out_q.tx_seq == '0))
    else $error("payload or sequence on a beat without transmission");

endmodule
